// ===== hw/rtl/rme_pkg.sv =====
package rme_pkg;

	localparam int DATA_W     = 16;
	localparam int FRAC_W     = DATA_W - 4;
	localparam int ANGLE_W    = 16;
	localparam int STEPS      = 14;
	localparam int THR_W      = 12;

	// Square root of a sum of squares of input elements.
	localparam int SQ_W       = 2 * DATA_W;
	localparam int RT_W       = SQ_W / 2;
	localparam int REM_W      = RT_W + 4;

	// Row normalization: |m| * 2^F + len/2, quotient never above 2^F.
	localparam int NUM_W      = DATA_W + FRAC_W;
	localparam int Q_W        = FRAC_W + 1;
	localparam int N_W        = Q_W + 1;

	// Arctangent unit.
	localparam int OP_W       = N_W + 1;
	localparam int SCALE_SH   = 34 - DATA_W;
	localparam int CW         = OP_W + SCALE_SH + 3;
	localparam int Z_W        = 32;
	localparam logic [Z_W-1:0] HALF_TURN = Z_W'(1) << (Z_W - 1);

	localparam int SQRT_LAT   = RT_W;
	localparam int DIV_LAT    = Q_W;
	localparam int CORDIC_LAT = STEPS + 1;
	localparam int PIPE_LAT   = 2 + SQRT_LAT + DIV_LAT + 2 + SQRT_LAT + 1 + CORDIC_LAT;

	typedef struct packed {
		logic [ANGLE_W-1:0] a1;
		logic [ANGLE_W-1:0] a2;
		logic [ANGLE_W-1:0] a3;
		logic               sing;
	} rme_result_t;

	// atan(2^-i) as a binary angle, one full turn is 2^32.
	function automatic logic [Z_W-1:0] atan_ang(input int i);
		case (i)
			0:       return 32'd536870912;
			1:       return 32'd316933406;
			2:       return 32'd167458907;
			3:       return 32'd85004756;
			4:       return 32'd42667331;
			5:       return 32'd21354465;
			6:       return 32'd10679838;
			7:       return 32'd5340245;
			8:       return 32'd2670163;
			9:       return 32'd1335087;
			10:      return 32'd667544;
			11:      return 32'd333772;
			12:      return 32'd166886;
			13:      return 32'd83443;
			14:      return 32'd41722;
			15:      return 32'd20861;
			16:      return 32'd10430;
			17:      return 32'd5215;
			18:      return 32'd2608;
			19:      return 32'd1304;
			20:      return 32'd652;
			21:      return 32'd326;
			22:      return 32'd163;
			23:      return 32'd81;
			24:      return 32'd41;
			25:      return 32'd20;
			26:      return 32'd10;
			27:      return 32'd5;
			28:      return 32'd3;
			29:      return 32'd1;
			default: return '0;
		endcase
	endfunction

	// Round a full-precision angle to the output width, wrapping.
	function automatic logic [ANGLE_W-1:0] rnd_ang(input logic [Z_W-1:0] z);
		logic [Z_W-1:0] t;
		t = z + (Z_W'(1) << (Z_W - ANGLE_W - 1));
		return t[Z_W-1 -: ANGLE_W];
	endfunction

endpackage

// ===== hw/rtl/rme_sqrt.sv =====
module rme_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rme_pkg::SQ_W-1:0]  radicand,
	output logic [rme_pkg::RT_W-1:0]  root
);
	import rme_pkg::*;

	// One result bit per stage, restoring digit-by-digit method.
	logic [SQ_W-1:0]  rad_s  [0:RT_W];
	logic [REM_W-1:0] rem_s  [0:RT_W];
	logic [RT_W-1:0]  root_s [0:RT_W];

	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < RT_W; g++) begin : g_step
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             fits;

		always_comb begin
			rem_sh = {rem_s[g][REM_W-3:0], rad_s[g][SQ_W-1 -: 2]};
			trial  = {{(REM_W - RT_W - 2){1'b0}}, root_s[g], 2'b01};
			fits   = (rem_sh >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= {rad_s[g][SQ_W-3:0], 2'b00};
				rem_s[g+1]  <= fits ? (rem_sh - trial) : rem_sh;
				root_s[g+1] <= {root_s[g][RT_W-2:0], fits};
			end
		end
	end

	assign root = root_s[RT_W];

endmodule

// ===== hw/rtl/rme_div.sv =====
module rme_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rme_pkg::DATA_W-1:0] elem,
	input  logic [rme_pkg::RT_W-1:0]          len,
	output logic signed [rme_pkg::N_W-1:0]    norm
);
	import rme_pkg::*;

	// Rounded quotient |elem| * 2^F / len, one quotient bit per stage.
	logic [DATA_W-1:0] mag;
	logic [NUM_W-1:0]  rem_s  [0:Q_W];
	logic [Q_W-1:0]    q_s    [0:Q_W];
	logic [RT_W-1:0]   len_s  [0:Q_W];
	logic              neg_s  [0:Q_W];
	logic              zero_s [0:Q_W];
	logic [N_W-1:0]    q_ext;

	assign mag       = elem[DATA_W-1] ? DATA_W'(-elem) : DATA_W'(elem);
	assign rem_s[0]  = {mag, {FRAC_W{1'b0}}} + NUM_W'(len >> 1);
	assign q_s[0]    = '0;
	assign len_s[0]  = len;
	assign neg_s[0]  = elem[DATA_W-1];
	assign zero_s[0] = (len == '0);

	for (genvar g = 0; g < Q_W; g++) begin : g_step
		logic [NUM_W-1:0] den;
		logic             fits;

		always_comb begin
			den  = NUM_W'(len_s[g]) << (Q_W - 1 - g);
			fits = (rem_s[g] >= den);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= fits ? (rem_s[g] - den) : rem_s[g];
				q_s[g+1]    <= {q_s[g][Q_W-2:0], fits};
				len_s[g+1]  <= len_s[g];
				neg_s[g+1]  <= neg_s[g];
				zero_s[g+1] <= zero_s[g];
			end
		end
	end

	assign q_ext = {1'b0, q_s[Q_W]};

	always_comb begin
		if (zero_s[Q_W] || (len_s[Q_W] == '0)) begin
			norm = '0;
		end else if (neg_s[Q_W]) begin
			norm = -signed'(q_ext);
		end else begin
			norm = signed'(q_ext);
		end
	end

endmodule

// ===== hw/rtl/rme_cordic.sv =====
module rme_cordic (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [rme_pkg::OP_W-1:0] op_y,
	input  logic signed [rme_pkg::OP_W-1:0] op_x,
	output logic [rme_pkg::Z_W-1:0]         z
);
	import rme_pkg::*;

	// Vectoring rotations, one per stage, after a quadrant fold stage.
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] x_s    [1:STEPS+1];
	logic signed [CW-1:0] y_s    [1:STEPS+1];
	logic [Z_W-1:0]       z_s    [1:STEPS+1];
	logic                 zero_s [1:STEPS+1];

	assign xs = CW'(op_x) <<< SCALE_SH;
	assign ys = CW'(op_y) <<< SCALE_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			if (op_x < 0) begin
				x_s[1] <= -xs;
				y_s[1] <= -ys;
				z_s[1] <= HALF_TURN;
			end else begin
				x_s[1] <= xs;
				y_s[1] <= ys;
				z_s[1] <= '0;
			end
			zero_s[1] <= (op_x == '0) && (op_y == '0);
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = y_s[g+1] >>> g;
		assign dy = x_s[g+1] >>> g;

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[g+1] < 0) begin
					x_s[g+2] <= x_s[g+1] - dx;
					y_s[g+2] <= y_s[g+1] + dy;
					z_s[g+2] <= z_s[g+1] - atan_ang(g);
				end else begin
					x_s[g+2] <= x_s[g+1] + dx;
					y_s[g+2] <= y_s[g+1] - dy;
					z_s[g+2] <= z_s[g+1] + atan_ang(g);
				end
				zero_s[g+2] <= zero_s[g+1];
			end
		end
	end

	assign z = zero_s[STEPS+1] ? '0 : z_s[STEPS+1];

endmodule

// ===== hw/rtl/rme_outq.sv =====
module rme_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rme_pkg::rme_result_t push_data,
	output logic                 ready,
	output logic                 pop_valid,
	input  logic                 pop_stall,
	output rme_pkg::rme_result_t pop_data
);
	import rme_pkg::*;

	// Two-entry queue; the pipeline freezes only while both entries are full.
	rme_result_t ent_q [0:1];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign ready     = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop       = pop_valid && !pop_stall;
	assign pop_data  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/rotation_matrix_to_euler.sv =====
// Throughput: one matrix per cycle; the pipeline freezes only while both
// entries of the two-entry output queue hold results that are not taken.
// Reset: arst_n clears all valid bits, the queue and sets the singular
// threshold to 1; pipeline data registers are not reset.
module rotation_matrix_to_euler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               mat_valid,
	output logic                               mat_stall,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_00,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_01,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_02,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_10,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_11,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_12,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_20,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_21,
	input  logic signed [rme_pkg::DATA_W-1:0]  elem_22,
	input  logic                               cfg_wr_en,
	input  logic [rme_pkg::THR_W-1:0]          cfg_wr_data,
	output logic                               ang_valid,
	input  logic                               ang_stall,
	output logic signed [rme_pkg::ANGLE_W-1:0] angle_first,
	output logic signed [rme_pkg::ANGLE_W-1:0] angle_second,
	output logic signed [rme_pkg::ANGLE_W-1:0] angle_third,
	output logic                               is_singular
);
	import rme_pkg::*;

	// Only seven normalized elements are ever used: n00, the whole of row 1
	// and the whole of row 2. They are kept in this order.
	localparam int KEEP_N = 7;
	localparam int K00 = 0;
	localparam int K10 = 1;
	localparam int K11 = 2;
	localparam int K12 = 3;
	localparam int K20 = 4;
	localparam int K21 = 5;
	localparam int K22 = 6;

	function automatic int keep_src(input int k);
		case (k)
			K00:     return 0;
			K10:     return 3;
			K11:     return 4;
			K12:     return 5;
			K20:     return 6;
			K21:     return 7;
			K22:     return 8;
			default: return 0;
		endcase
	endfunction

	function automatic int keep_row(input int k);
		case (k)
			K00:     return 0;
			K10:     return 1;
			K11:     return 1;
			K12:     return 1;
			default: return 2;
		endcase
	endfunction

	logic                      adv;
	logic                      accept;
	logic [PIPE_LAT:1]         vld_q;
	logic [THR_W-1:0]          thr_q;

	logic signed [DATA_W-1:0]  m_in     [0:8];
	logic signed [SQ_W-1:0]    sq_in    [0:8];
	logic [SQ_W-1:0]           sq_s1    [0:8];
	logic signed [DATA_W-1:0]  m_s1     [0:KEEP_N-1];
	logic [SQ_W-1:0]           sum_s2   [0:2];
	logic signed [DATA_W-1:0]  m_dly    [0:SQRT_LAT][0:KEEP_N-1];
	logic [RT_W-1:0]           row_len  [0:2];
	logic signed [N_W-1:0]     norm     [0:KEEP_N-1];

	logic signed [N_W-1:0]     n_s32    [0:KEEP_N-1];
	logic signed [2*N_W-1:0]   nsq00_s32;
	logic signed [2*N_W-1:0]   nsq10_s32;
	logic [SQ_W-1:0]           sy_sq_s33;
	logic signed [N_W-1:0]     n_dly    [0:SQRT_LAT][0:KEEP_N-1];
	logic [RT_W-1:0]           sy;
	logic                      sing;

	logic signed [OP_W-1:0]    opy_s50  [0:2];
	logic signed [OP_W-1:0]    opx_s50  [0:2];
	logic [CORDIC_LAT:0]       sing_dly;
	logic [Z_W-1:0]            z_out    [0:2];

	rme_result_t               res;
	rme_result_t               q_data;
	logic                      push;

	// The whole pipeline advances together; a transfer is taken whenever the
	// output queue has room, so valid bits never collide.
	assign accept    = mat_valid && adv;
	assign mat_stall = !adv;

	assign m_in[0] = elem_00;
	assign m_in[1] = elem_01;
	assign m_in[2] = elem_02;
	assign m_in[3] = elem_10;
	assign m_in[4] = elem_11;
	assign m_in[5] = elem_12;
	assign m_in[6] = elem_20;
	assign m_in[7] = elem_21;
	assign m_in[8] = elem_22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= THR_W'(1);
		end else begin
			if (adv) begin
				vld_q <= {vld_q[PIPE_LAT-1:1], accept};
			end
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
		end
	end

	// Stage 1 squares every element, stage 2 sums each row.
	for (genvar i = 0; i < 9; i++) begin : g_sq
		assign sq_in[i] = m_in[i] * m_in[i];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				sq_s1[i] <= sq_in[i];
			end
			for (int k = 0; k < KEEP_N; k++) begin
				m_s1[k] <= m_in[keep_src(k)];
			end
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= sq_s1[3*r] + sq_s1[3*r+1] + sq_s1[3*r+2];
			end
			for (int k = 0; k < KEEP_N; k++) begin
				m_dly[0][k] <= m_s1[k];
			end
			for (int d = 0; d < SQRT_LAT; d++) begin
				for (int k = 0; k < KEEP_N; k++) begin
					m_dly[d+1][k] <= m_dly[d][k];
				end
			end
		end
	end

	// Row lengths. The elements ride alongside so they meet their row length.
	for (genvar r = 0; r < 3; r++) begin : g_len
		rme_sqrt u_len (
			.clk      (clk),
			.en       (adv),
			.radicand (sum_s2[r]),
			.root     (row_len[r])
		);
	end

	// Each kept element is divided by the length of its own row.
	for (genvar k = 0; k < KEEP_N; k++) begin : g_norm
		rme_div u_div (
			.clk  (clk),
			.en   (adv),
			.elem (m_dly[SQRT_LAT][k]),
			.len  (row_len[keep_row(k)]),
			.norm (norm[k])
		);
	end

	// sy = sqrt(n00^2 + n10^2): squares, then sum, then a separate instance of the root unit.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < KEEP_N; k++) begin
				n_s32[k] <= norm[k];
			end
			nsq00_s32 <= norm[K00] * norm[K00];
			nsq10_s32 <= norm[K10] * norm[K10];
			sy_sq_s33 <= SQ_W'(nsq00_s32) + SQ_W'(nsq10_s32);
			for (int k = 0; k < KEEP_N; k++) begin
				n_dly[0][k] <= n_s32[k];
			end
			for (int d = 0; d < SQRT_LAT; d++) begin
				for (int k = 0; k < KEEP_N; k++) begin
					n_dly[d+1][k] <= n_dly[d][k];
				end
			end
		end
	end

	rme_sqrt u_sy (
		.clk      (clk),
		.en       (adv),
		.radicand (sy_sq_s33),
		.root     (sy)
	);

	// A threshold of zero can never be undercut, so that setting disables the
	// singular branch with no extra logic.
	assign sing = (sy < RT_W'(thr_q));

	// Operand select. The singular case swaps the first angle onto row 1 and
	// feeds zeros to the third unit, which then returns an angle of zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (sing) begin
				opy_s50[0] <= -OP_W'(n_dly[SQRT_LAT][K12]);
				opx_s50[0] <= OP_W'(n_dly[SQRT_LAT][K11]);
				opy_s50[2] <= '0;
				opx_s50[2] <= '0;
			end else begin
				opy_s50[0] <= OP_W'(n_dly[SQRT_LAT][K21]);
				opx_s50[0] <= OP_W'(n_dly[SQRT_LAT][K22]);
				opy_s50[2] <= OP_W'(n_dly[SQRT_LAT][K10]);
				opx_s50[2] <= OP_W'(n_dly[SQRT_LAT][K00]);
			end
			opy_s50[1] <= -OP_W'(n_dly[SQRT_LAT][K20]);
			opx_s50[1] <= signed'(OP_W'(sy));
			sing_dly   <= {sing_dly[CORDIC_LAT-1:0], sing};
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_atan
		rme_cordic u_cordic (
			.clk  (clk),
			.en   (adv),
			.op_y (opy_s50[c]),
			.op_x (opx_s50[c]),
			.z    (z_out[c])
		);
	end

	// The first angle is the negated z rotation; negation wraps modulo a turn.
	always_comb begin
		res.a1   = rnd_ang(Z_W'(0) - z_out[0]);
		res.a2   = rnd_ang(z_out[1]);
		res.a3   = rnd_ang(z_out[2]);
		res.sing = sing_dly[CORDIC_LAT];
	end

	assign push = adv && vld_q[PIPE_LAT];

	rme_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.ready     (adv),
		.pop_valid (ang_valid),
		.pop_stall (ang_stall),
		.pop_data  (q_data)
	);

	assign angle_first  = signed'(q_data.a1);
	assign angle_second = signed'(q_data.a2);
	assign angle_third  = signed'(q_data.a3);
	assign is_singular  = q_data.sing;

`ifndef ASSERT_OFF
	a_sing_third_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ang_valid && is_singular) |-> (angle_third == '0))
		else $error("third angle not zero on a singular result");

	a_thr_zero_never_sing: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (thr_q == '0)) |=> !sing_dly[0])
		else $error("singular flagged with a zero threshold");

	a_freeze_holds_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline valid bits moved while frozen");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_valid && !mat_stall) |=> vld_q[1])
		else $error("accepted matrix did not enter the pipeline");
`endif

endmodule

// ===== dv/rotation_matrix_to_euler_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the rotation matrix to Euler angle converter. A behavioral
// predictor works out the three binary angles and the singular flag for each
// matrix transfer; a monitor compares every angle transfer with the oldest
// prediction, field by field.
module rotation_matrix_to_euler_tb;
	import rme_pkg::*;

	localparam int LATENCY     = 65;
	localparam int WATCH_LIMIT = 4000;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef elem_t matrix_t [9];

	logic clk;
	logic arst_n;
	logic mat_valid;
	logic mat_stall;
	elem_t elem [9];
	logic cfg_wr_en;
	logic [THR_W-1:0] cfg_wr_data;
	logic ang_valid;
	logic ang_stall;
	logic signed [ANGLE_W-1:0] angle_first;
	logic signed [ANGLE_W-1:0] angle_second;
	logic signed [ANGLE_W-1:0] angle_third;
	logic is_singular;

	// Model copy of the threshold register and the queue of predicted angles.
	logic [THR_W-1:0] threshold_model;
	rme_result_t angles_due [$];
	int error_count;
	int idle_cycles;
	bit gaps_on;

	rotation_matrix_to_euler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.mat_valid   (mat_valid),
		.mat_stall   (mat_stall),
		.elem_00     (elem[0]),
		.elem_01     (elem[1]),
		.elem_02     (elem[2]),
		.elem_10     (elem[3]),
		.elem_11     (elem[4]),
		.elem_12     (elem[5]),
		.elem_20     (elem[6]),
		.elem_21     (elem[7]),
		.elem_22     (elem[8]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ang_valid   (ang_valid),
		.ang_stall   (ang_stall),
		.angle_first (angle_first),
		.angle_second(angle_second),
		.angle_third (angle_third),
		.is_singular (is_singular)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Bitwise integer square root, floor.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Vectoring arctangent with 32-bit binary angle result. Operands are scaled
	// up first, and the left half plane is folded over by adding half a turn.
	function automatic logic [31:0] arctan2(input longint y, input longint x);
		logic [31:0] z;
		longint dx, dy;
		logic [31:0] step_ang [14];
		step_ang = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
			32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443};
		if (x == 0 && y == 0)
			return '0;
		z = '0;
		x = x * (longint'(1) << (34 - DATA_W));
		y = y * (longint'(1) << (34 - DATA_W));
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x -= dx;
				y += dy;
				z -= step_ang[i];
			end else begin
				x += dx;
				y -= dy;
				z += step_ang[i];
			end
		end
		return z;
	endfunction

	function automatic logic [ANGLE_W-1:0] round_angle(input logic [31:0] z);
		logic [31:0] t;
		t = z + (32'd1 << (31 - ANGLE_W));
		return t[31 -: ANGLE_W];
	endfunction

	// Normalizes every row by its own length and derives the Euler angles.
	function automatic rme_result_t euler_of(input matrix_t m);
		longint n [9];
		longint unsigned sum, len, mg, q, sy;
		logic [31:0] z1, z2, z3;
		rme_result_t res;
		for (int r = 0; r < 3; r++) begin
			sum = 0;
			for (int c = 0; c < 3; c++)
				sum += longint'(m[r*3+c]) * longint'(m[r*3+c]);
			len = int_sqrt(sum);
			for (int c = 0; c < 3; c++) begin
				mg = (m[r*3+c] < 0) ? -longint'(m[r*3+c]) : longint'(m[r*3+c]);
				q = (len == 0) ? 0 : ((mg << FRAC_W) + (len >> 1)) / len;
				n[r*3+c] = (m[r*3+c] < 0) ? -longint'(q) : longint'(q);
			end
		end
		sy = int_sqrt(n[0] * n[0] + n[3] * n[3]);
		res.sing = sy < threshold_model;
		z2 = arctan2(-n[6], longint'(sy));
		if (!res.sing) begin
			z3 = arctan2(n[3], n[0]);
			z1 = arctan2(n[7], n[8]);
		end else begin
			z3 = '0;
			z1 = arctan2(-n[5], n[4]);
		end
		res.a1 = round_angle(-z1);
		res.a2 = round_angle(z2);
		res.a3 = round_angle(z3);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Sends one matrix with an optional random gap first, then holds it until
	// the transfer takes place.
	task automatic send_matrix(input matrix_t m);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			mat_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		for (int i = 0; i < 9; i++)
			elem[i] <= m[i];
		mat_valid <= 1'b1;
		@(posedge clk);
		while (mat_stall)
			@(posedge clk);
		angles_due.push_back(euler_of(m));
		@(negedge clk);
	endtask

	task automatic drain_results();
		mat_valid <= 1'b0;
		while (angles_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		threshold_model = value;
	endtask

	function automatic matrix_t random_matrix();
		matrix_t m;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			case (mode)
				0: m[i] = elem_t'($urandom);
				1: m[i] = elem_t'($urandom_range(0, 6) == 0 ? 0 : $urandom_range(0, 3) - 1);
				default: m[i] = elem_t'(int'($urandom_range(0, 8192)) - 4096);
			endcase
		end
		// Now and then force a near-singular first column.
		if (mode == 2) begin
			m[0] = elem_t'(int'($urandom_range(0, 8)) - 4);
			m[3] = elem_t'(int'($urandom_range(0, 8)) - 4);
		end
		return m;
	endfunction

	// Extremes, zero rows and the singular case at the reset threshold.
	task automatic test_directed();
		matrix_t m;
		elem_t vals [6];
		vals = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh1000, -16'sh1000, 16'sh0001};
		foreach (vals[v]) begin
			foreach (m[i])
				m[i] = vals[v];
			send_matrix(m);
		end
		m = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		// Gimbal lock: first column zero except the bottom element.
		m = '{0, 16'sh1000, 0, 0, 0, 16'sh1000, -16'sh1000, 0, 0};
		send_matrix(m);
		m = '{0, 16'sh1000, 0, 0, 0, -16'sh1000, 16'sh1000, 0, 0};
		send_matrix(m);
		// Angle at pi: negative x with zero y.
		m = '{-16'sh1000, 0, 0, 0, -16'sh1000, 0, 0, 0, -16'sh1000};
		send_matrix(m);
		m = '{16'sh5555, -16'shaaa, 16'sh2aaa, 16'sh7fff, -16'sh8000, 16'sh7fff,
			-16'sh8000, 16'sh7fff, -16'sh8000};
		send_matrix(m);
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_matrix(random_matrix());
	endtask

	// Sweeps the threshold through its extremes and a few middle values.
	task automatic test_thresholds();
		logic [THR_W-1:0] settings [5];
		settings = '{12'd0, 12'd4095, 12'd64, 12'd2048, 12'd1};
		foreach (settings[s]) begin
			drain_results();
			write_threshold(settings[s]);
			test_random(150);
		end
	endtask

	// Monitor: sample at the rising edge, drive the stall at the falling edge.
	always @(posedge clk) begin
		rme_result_t want;
		if (arst_n && ang_valid && !ang_stall) begin
			if (angles_due.size() == 0) begin
				report_mismatch("unexpected angle transfer", angle_first, '0);
			end else begin
				want = angles_due.pop_front();
				if (angle_first !== want.a1)
					report_mismatch("angle_first", angle_first, want.a1);
				if (angle_second !== want.a2)
					report_mismatch("angle_second", angle_second, want.a2);
				if (angle_third !== want.a3)
					report_mismatch("angle_third", angle_third, want.a3);
				if (is_singular !== want.sing)
					report_mismatch("is_singular", is_singular, want.sing);
			end
		end
	end

	// Receiver stalls in random bursts while gaps are enabled.
	initial begin
		int burst;
		ang_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 18);
				ang_stall <= 1'b1;
				repeat (burst) @(negedge clk);
			end
			ang_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((mat_valid && !mat_stall) || (ang_valid && !ang_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		mat_valid = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		foreach (elem[i])
			elem[i] = '0;
		error_count = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		threshold_model = 12'd1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(400);
		test_thresholds();
		// Final stretch at full rate with no idling on either side.
		drain_results();
		write_threshold(12'd300);
		gaps_on = 1'b0;
		test_random(800);
		drain_results();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
